// ===== sv/b64d_pkg.sv =====
package b64d_pkg;

  localparam int SEXTET_W  = 6;
  localparam int BYTE_W    = 8;
  localparam int LEN_OUT_W = 24;
  localparam int GROUP_N   = 3;

  localparam logic [1:0] STOP_NONE    = 2'd0;
  localparam logic [1:0] STOP_PAD     = 2'd1;
  localparam logic [1:0] STOP_INVALID = 2'd2;

  localparam logic [7:0] CHAR_PAD   = 8'h3d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;

  typedef struct packed {
    logic                valid;
    logic [SEXTET_W-1:0] value;
  } sextet_t;

  // Op for the back end: up to three bytes, closing info on last.
  typedef struct packed {
    logic [GROUP_N-1:0][BYTE_W-1:0] data;
    logic [1:0]                     nb;
    logic                           last;
    logic [1:0]                     reason;
    logic [LEN_OUT_W-1:0]           length;
  } op_t;

  function automatic sextet_t sextet_lookup(input logic [7:0] ch);
    sextet_t s;
    s.valid = 1'b1;
    s.value = '0;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      s.value = SEXTET_W'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      s.value = SEXTET_W'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.value = SEXTET_W'(ch - 8'h30 + 8'd52);
    end else if (ch == CHAR_PLUS) begin
      s.value = SEXTET_W'(62);
    end else if (ch == CHAR_SLASH) begin
      s.value = SEXTET_W'(63);
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== sv/b64d_front.sv =====
module b64d_front import b64d_pkg::*; #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           char_in,
  input  logic                 end_of_message,
  output op_t                  op,
  output logic                 op_push,
  input  logic                 op_full
);

  localparam int EXT_W = (LENGTH_BITS > LEN_OUT_W) ? LENGTH_BITS : LEN_OUT_W;

  logic [SEXTET_W-1:0]    group [GROUP_N];
  logic [SEXTET_W-1:0]    group_next [GROUP_N];
  logic [1:0]             fill, fill_next;
  logic [1:0]             cause, cause_next;
  logic [LENGTH_BITS-1:0] total, total_next;
  logic [LENGTH_BITS:0]   total_sum;
  logic [EXT_W-1:0]       total_ext;
  logic [1:0]             nb;
  logic                   accept;
  logic                   group_done;
  sextet_t                sx;

  assign full   = op_full;
  assign accept = push && !full;
  assign sx     = sextet_lookup(char_in);

  always_comb begin
    group_next = group;
    fill_next  = fill;
    cause_next = cause;
    group_done = 1'b0;
    if (cause == STOP_NONE) begin
      if (!sx.valid) begin
        cause_next = (char_in == CHAR_PAD) ? STOP_PAD : STOP_INVALID;
      end else begin
        unique case (fill)
          2'd0: begin
            group_next[0] = sx.value;
            fill_next     = 2'd1;
          end
          2'd1: begin
            group_next[1] = sx.value;
            fill_next     = 2'd2;
          end
          2'd2: begin
            group_next[2] = sx.value;
            fill_next     = 2'd3;
          end
          default: begin
            group_done = 1'b1;
            fill_next  = 2'd0;
          end
        endcase
      end
    end

    if (group_done) begin
      nb = 2'd3;
    end else if (end_of_message && fill_next[1]) begin
      nb = fill_next - 2'd1;
    end else begin
      nb = 2'd0;
    end

    total_sum = {1'b0, total} + (LENGTH_BITS + 1)'(nb);
    if (total_sum[LENGTH_BITS]) begin
      total_next = '1;
    end else begin
      total_next = total_sum[LENGTH_BITS-1:0];
    end
    total_ext = EXT_W'(total_next);

    op.data[0] = {group_next[0], group_next[1][5:4]};
    op.data[1] = {group_next[1][3:0], group_next[2][5:2]};
    op.data[2] = {group_next[2][1:0], sx.value};
    op.nb      = nb;
    op.last    = end_of_message;
    op.reason  = cause_next;
    op.length  = total_ext[LEN_OUT_W-1:0];
  end

  assign op_push = accept && (nb != 2'd0 || end_of_message);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GROUP_N; i++) group[i] <= '0;
      fill  <= '0;
      cause <= STOP_NONE;
      total <= '0;
    end else if (accept) begin
      if (end_of_message) begin
        // close the message: back to the idle state
        for (int i = 0; i < GROUP_N; i++) group[i] <= '0;
        fill  <= '0;
        cause <= STOP_NONE;
        total <= '0;
      end else begin
        group <= group_next;
        fill  <= fill_next;
        cause <= cause_next;
        total <= total_next;
      end
    end
  end

endmodule

// ===== sv/b64d_queue.sv =====
module b64d_queue import b64d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  input  logic pop,
  output op_t  head,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/b64d_back.sv =====
module b64d_back import b64d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  op_t                  op,
  input  logic                 op_valid,
  output logic                 op_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [BYTE_W-1:0]    data_byte,
  output logic                 byte_present,
  output logic                 last,
  output logic [1:0]           stop_reason,
  output logic [LEN_OUT_W-1:0] decoded_length
);

  logic                 out_valid;
  logic [1:0]           k;
  logic                 load;
  logic                 head_done;
  logic                 present_c;
  logic                 last_c;
  logic [BYTE_W-1:0]    byte_c;

  assign empty     = !out_valid;
  assign load      = op_valid && (!out_valid || pop);
  assign head_done = (op.nb == 2'd0) || (k == op.nb - 2'd1);
  assign op_pop    = load && head_done;

  always_comb begin
    present_c = (op.nb != 2'd0);
    last_c    = op.last && head_done;
    byte_c    = '0;
    if (present_c) begin
      unique case (k)
        2'd0:    byte_c = op.data[0];
        2'd1:    byte_c = op.data[1];
        default: byte_c = op.data[2];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        // advance through the bytes of the head op, drop it after the last one
        k <= head_done ? 2'd0 : k + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte      <= byte_c;
      byte_present   <= present_c;
      last           <= last_c;
      stop_reason    <= last_c ? op.reason : STOP_NONE;
      decoded_length <= last_c ? op.length : '0;
    end
  end

endmodule

// ===== sv/base64_stream_decoder.sv =====
// Path: the op of an accepted character is registered in the op queue, then in the output
// register once the output is free; a group's beats follow one per cycle while pop is held.
// Throughput: one character per cycle in while full is low; one result beat per cycle out
// while pop is held. Four characters of a group give three beats; the back end keeps up.
// A short op queue between front and back end absorbs the burst of a completed group.
// Reset (rst, synchronous): clears the group, byte counter, stop state, queue and output.
module base64_stream_decoder import b64d_pkg::*; #(
  parameter int LENGTH_BITS = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           char_in,
  input  logic                 end_of_message,
  output logic                 empty,
  input  logic                 pop,
  output logic [BYTE_W-1:0]    data_byte,
  output logic                 byte_present,
  output logic                 last,
  output logic [1:0]           stop_reason,
  output logic [LEN_OUT_W-1:0] decoded_length
);

  op_t  front_op;
  op_t  head_op;
  logic front_push;
  logic queue_full;
  logic queue_empty;
  logic back_pop;

  b64d_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .char_in       (char_in),
    .end_of_message(end_of_message),
    .op            (front_op),
    .op_push       (front_push),
    .op_full       (queue_full)
  );

  b64d_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_data(front_op),
    .full     (queue_full),
    .pop      (back_pop),
    .head     (head_op),
    .empty    (queue_empty)
  );

  b64d_back u_back (
    .clk           (clk),
    .rst           (rst),
    .op            (head_op),
    .op_valid      (!queue_empty),
    .op_pop        (back_pop),
    .empty         (empty),
    .pop           (pop),
    .data_byte     (data_byte),
    .byte_present  (byte_present),
    .last          (last),
    .stop_reason   (stop_reason),
    .decoded_length(decoded_length)
  );

endmodule
